// ----- rtl/stni_pkg.sv -----
// Shared types and constants for the sorted top-N insertion list.
// Used by the list cells, the output buffer and the top level.
package stni_pkg;

	localparam int DEF_LIST_DEPTH = 8;
	localparam int WORD_W = 32;
	localparam int RANK_W = 8;
	localparam int PLACED_W = 3;

	localparam logic ACT_SUBMIT = 1'b0;
	localparam logic ACT_READ = 1'b1;

	typedef struct packed {
		logic [WORD_W-1:0] score;
		logic [WORD_W-1:0] pa;
		logic [WORD_W-1:0] pb;
		logic [WORD_W-1:0] pt;
	} record_t;

	typedef struct packed {
		logic accepted;
		logic [PLACED_W-1:0] placed_rank;
		logic entry_valid;
		record_t entry;
		logic [WORD_W-1:0] best_score;
	} result_t;

endpackage

// ----- rtl/stni_cell.sv -----
// One slot of the ranked list: holds a record, compares it with the incoming score
// and takes either the new record or its upper neighbor's record on an insert.
// Depends on stni_pkg.
module stni_cell (
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  stni_pkg::record_t new_rec,
	input  logic prev_gt,
	input  stni_pkg::record_t prev_rec,
	output logic gt,
	output stni_pkg::record_t rec
);
	import stni_pkg::*;

	record_t rec_q;

	// The list is kept descending, so the compare results along the chain form
	// a run of zeros followed by ones. The first cell with a one takes the new
	// record; the cells below it take their neighbor's record.
	assign gt = new_rec.score > rec_q.score;
	assign rec = rec_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_q <= '0;
		end else if (load && gt) begin
			rec_q <= prev_gt ? prev_rec : new_rec;
		end
	end

endmodule

// ----- rtl/stni_outbuf.sv -----
// Output register with a skid stage, so a new transfer can be taken while a
// finished result still waits downstream. Depends on stni_pkg.
module stni_outbuf (
	input  logic clk,
	input  logic arst_n,
	input  logic in_fire,
	input  stni_pkg::result_t res,
	output logic full,
	output logic out_valid,
	input  logic out_stall,
	output stni_pkg::result_t out_res
);
	import stni_pkg::*;

	result_t out_q;
	result_t skid_q;
	logic out_valid_q;
	logic skid_valid_q;

	assign full = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_res = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			if (skid_valid_q) begin
				out_valid_q <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= in_fire;
			end
		end else if (in_fire) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || !out_stall) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (in_fire) begin
				out_q <= res;
			end
		end else if (in_fire) begin
			skid_q <= res;
		end
	end

endmodule

// ----- rtl/sorted_top_n_insert.sv -----
// Sorted top-N list: keeps the LIST_DEPTH best records in descending score order.
// One transfer is taken per clock cycle unless stalled, each giving one result;
// the chain of slot cells compares and shifts every slot in parallel, so a
// submit or a read completes in the cycle it is accepted. The input stalls only
// when both the output register and its skid stage hold results. The list is all
// zeros after reset. Ties land below the existing entry; a zero score is rejected.
// Depends on stni_pkg, stni_cell and stni_outbuf.
module sorted_top_n_insert #(
	parameter int LIST_DEPTH = stni_pkg::DEF_LIST_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic action,
	input  logic [stni_pkg::WORD_W-1:0] new_score,
	input  logic [stni_pkg::WORD_W-1:0] payload_a,
	input  logic [stni_pkg::WORD_W-1:0] payload_b,
	input  logic [stni_pkg::WORD_W-1:0] payload_time,
	input  logic [stni_pkg::RANK_W-1:0] query_rank,
	output logic out_valid,
	input  logic out_stall,
	output logic accepted,
	output logic [stni_pkg::PLACED_W-1:0] placed_rank,
	output logic entry_valid,
	output logic [stni_pkg::WORD_W-1:0] entry_score,
	output logic [stni_pkg::WORD_W-1:0] entry_payload_a,
	output logic [stni_pkg::WORD_W-1:0] entry_payload_b,
	output logic [stni_pkg::WORD_W-1:0] entry_time,
	output logic [stni_pkg::WORD_W-1:0] best_score
);
	import stni_pkg::*;

	logic in_fire;
	logic submit;
	logic buf_full;
	record_t new_rec;
	logic gt [LIST_DEPTH];
	record_t rec [LIST_DEPTH];
	logic prev_gt [LIST_DEPTH];
	record_t prev_rec [LIST_DEPTH];
	result_t res;
	result_t out_res;

	assign in_stall = buf_full;
	assign in_fire = in_valid && !buf_full;
	assign submit = in_fire && (action == ACT_SUBMIT);

	assign new_rec.score = new_score;
	assign new_rec.pa = payload_a;
	assign new_rec.pb = payload_b;
	assign new_rec.pt = payload_time;

	for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign prev_gt[i] = 1'b0;
			assign prev_rec[i] = '0;
		end else begin : g_link
			assign prev_gt[i] = gt[i-1];
			assign prev_rec[i] = rec[i-1];
		end

		stni_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.load(submit),
			.new_rec(new_rec),
			.prev_gt(prev_gt[i]),
			.prev_rec(prev_rec[i]),
			.gt(gt[i]),
			.rec(rec[i])
		);
	end

	// The result is formed from the list as it stands before the edge; the head
	// score after the item is the new score when the record lands in slot zero.
	always_comb begin
		res = '0;
		if (action == ACT_SUBMIT) begin
			for (int i = 0; i < LIST_DEPTH; i++) begin
				if (gt[i] && !prev_gt[i]) begin
					res.accepted = 1'b1;
					res.placed_rank = PLACED_W'(i);
				end
			end
		end else begin
			res.entry_valid = {1'b0, query_rank} < (RANK_W + 1)'(LIST_DEPTH);
			for (int i = 0; i < LIST_DEPTH; i++) begin
				if ({1'b0, query_rank} == (RANK_W + 1)'(i)) begin
					res.entry = rec[i];
				end
			end
		end
		res.best_score = (action == ACT_SUBMIT && gt[0]) ? new_score : rec[0].score;
	end

	stni_outbuf u_outbuf (
		.clk(clk),
		.arst_n(arst_n),
		.in_fire(in_fire),
		.res(res),
		.full(buf_full),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_res(out_res)
	);

	assign accepted = out_res.accepted;
	assign placed_rank = out_res.placed_rank;
	assign entry_valid = out_res.entry_valid;
	assign entry_score = out_res.entry.score;
	assign entry_payload_a = out_res.entry.pa;
	assign entry_payload_b = out_res.entry.pb;
	assign entry_time = out_res.entry.pt;
	assign best_score = out_res.best_score;

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the sorted top-N insertion list (sorted_top_n_insert).
// Keeps a shadow copy of the ranked list, predicts each result and checks it field by field.
// Depends on stni_pkg and the sorted_top_n_insert RTL.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import stni_pkg::*;

	localparam int LIST_DEPTH = DEF_LIST_DEPTH;
	localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int CYCLE_LIMIT = 250000;
	localparam int DRAIN_CYCLES = 12;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic action;
	logic [WORD_W-1:0] new_score;
	logic [WORD_W-1:0] payload_a;
	logic [WORD_W-1:0] payload_b;
	logic [WORD_W-1:0] payload_time;
	logic [RANK_W-1:0] query_rank;
	logic out_valid;
	logic out_stall;
	logic accepted;
	logic [PLACED_W-1:0] placed_rank;
	logic entry_valid;
	logic [WORD_W-1:0] entry_score;
	logic [WORD_W-1:0] entry_payload_a;
	logic [WORD_W-1:0] entry_payload_b;
	logic [WORD_W-1:0] entry_time;
	logic [WORD_W-1:0] best_score;

	// Shadow of the ranked list and the results still owed by the block.
	record_t board [LIST_DEPTH];
	result_t outcomes_due [$];

	int mismatch_count;
	int cycle_count;
	int sender_gap_max;
	int receiver_hold_max;

	sorted_top_n_insert #(
		.LIST_DEPTH(LIST_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.new_score(new_score),
		.payload_a(payload_a),
		.payload_b(payload_b),
		.payload_time(payload_time),
		.query_rank(query_rank),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.accepted(accepted),
		.placed_rank(placed_rank),
		.entry_valid(entry_valid),
		.entry_score(entry_score),
		.entry_payload_a(entry_payload_a),
		.entry_payload_b(entry_payload_b),
		.entry_time(entry_time),
		.best_score(best_score)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Applies one item to the shadow list and returns the result it must produce.
	function automatic result_t board_step(input logic act, input logic [WORD_W-1:0] score,
			input logic [WORD_W-1:0] pa, input logic [WORD_W-1:0] pb,
			input logic [WORD_W-1:0] pt, input logic [RANK_W-1:0] rank);
		result_t r;
		int slot;
		r = '0;
		slot = -1;
		if (act == ACT_SUBMIT) begin
			if (score != '0) begin
				for (int k = 0; k < LIST_DEPTH; k++)
					if (slot < 0 && score > board[k].score)
						slot = k;
			end
			if (slot >= 0) begin
				for (int k = LIST_DEPTH - 1; k > slot; k--)
					board[k] = board[k - 1];
				board[slot] = '{score: score, pa: pa, pb: pb, pt: pt};
				r.accepted = 1'b1;
				r.placed_rank = slot[PLACED_W-1:0];
			end
		end else if (int'(rank) < LIST_DEPTH) begin
			r.entry_valid = 1'b1;
			r.entry = board[IDX_W'(rank)];
		end
		r.best_score = board[0].score;
		return r;
	endfunction

	task automatic note_mismatch(input string what, input logic [WORD_W-1:0] got,
			input logic [WORD_W-1:0] want);
		$display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
		mismatch_count++;
	endtask

	// Presents one item and returns at the edge where it transfers.
	task automatic send_item(input logic act, input logic [WORD_W-1:0] score,
			input logic [WORD_W-1:0] pa, input logic [WORD_W-1:0] pb,
			input logic [WORD_W-1:0] pt, input logic [RANK_W-1:0] rank);
		int gap;
		gap = $urandom_range(0, sender_gap_max);
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		action <= act;
		new_score <= score;
		payload_a <= pa;
		payload_b <= pb;
		payload_time <= pt;
		query_rank <= rank;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall !== 1'b0);
		outcomes_due.push_back(board_step(act, score, pa, pb, pt, rank));
	endtask

	task automatic hold_until_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (outcomes_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_empty_list();
		send_item(ACT_READ, 32'h0000_0000, 32'h0, 32'h0, 32'h0, 8'd0);
		send_item(ACT_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			RANK_W'(LIST_DEPTH - 1));
		send_item(ACT_READ, 32'h1234_5678, 32'h1, 32'h2, 32'h3, RANK_W'(LIST_DEPTH));
		send_item(ACT_READ, 32'h0, 32'h0, 32'h0, 32'h0, 8'hFF);
		// A zero score never enters, even into an empty list.
		send_item(ACT_SUBMIT, 32'h0, 32'hDEAD_BEEF, 32'hCAFE_F00D, 32'h0000_0100, 8'hFF);
	endtask

	task automatic test_ranking_order();
		send_item(ACT_SUBMIT, 32'd16, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 8'd0);
		send_item(ACT_SUBMIT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			8'hFF);
		// Equal scores go below the entry already held.
		send_item(ACT_SUBMIT, 32'd16, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'd3, 8'd0);
		send_item(ACT_SUBMIT, 32'd1, 32'h0000_0004, 32'h0000_0040, 32'd4, 8'd0);
		send_item(ACT_SUBMIT, 32'd1, 32'h0000_0005, 32'h0000_0050, 32'd5, 8'd0);
		send_item(ACT_SUBMIT, 32'd8, 32'h0000_0006, 32'h0000_0060, 32'd6, 8'd0);
		send_item(ACT_SUBMIT, 32'd32, 32'h0000_0007, 32'h0000_0070, 32'd7, 8'd0);
		send_item(ACT_SUBMIT, 32'd2, 32'h0000_0008, 32'h0000_0080, 32'd8, 8'd0);
		// The list is now full; a score equal to the last entry is turned away.
		send_item(ACT_SUBMIT, 32'd1, 32'h0000_0009, 32'h0000_0090, 32'd9, 8'd0);
		send_item(ACT_SUBMIT, 32'd0, 32'h0000_000A, 32'h0000_00A0, 32'd10, 8'd0);
		send_item(ACT_SUBMIT, 32'd3, 32'h0000_000B, 32'h0000_00B0, 32'd11, 8'd0);
		send_item(ACT_READ, 32'd0, 32'd0, 32'd0, 32'd0, 8'd0);
		send_item(ACT_READ, 32'd0, 32'd0, 32'd0, 32'd0, 8'd2);
		send_item(ACT_READ, 32'd0, 32'd0, 32'd0, 32'd0, 8'd3);
		send_item(ACT_READ, 32'd0, 32'd0, 32'd0, 32'd0, RANK_W'(LIST_DEPTH - 1));
	endtask

	// Mixed reads and submits; most scores sit next to a score already held so that
	// records land at every slot, tie with neighbors and push entries off the end.
	task automatic test_random_traffic(input int count, input int gap_max, input int hold_max);
		logic act;
		logic [WORD_W-1:0] score;
		logic [RANK_W-1:0] rank;
		int pick;
		sender_gap_max = gap_max;
		receiver_hold_max = hold_max;
		for (int n = 0; n < count; n++) begin
			act = ($urandom_range(0, 99) < 40) ? ACT_READ : ACT_SUBMIT;
			pick = $urandom_range(0, 99);
			if (pick < 55)
				score = board[IDX_W'($urandom_range(0, LIST_DEPTH - 1))].score
					+ $urandom_range(0, 2) - 1;
			else if (pick < 70)
				score = board[IDX_W'($urandom_range(0, LIST_DEPTH - 1))].score
					+ $urandom_range(0, 1000) - 500;
			else if (pick < 85)
				score = $urandom;
			else if (pick < 95)
				score = '0;
			else
				score = $urandom_range(1, 8);
			pick = $urandom_range(0, 9);
			if (pick < 8)
				rank = RANK_W'($urandom_range(0, LIST_DEPTH - 1));
			else if (pick == 8)
				rank = RANK_W'($urandom_range(LIST_DEPTH, 2 * LIST_DEPTH));
			else
				rank = RANK_W'($urandom_range(0, 255));
			send_item(act, score, $urandom, $urandom, $urandom, rank);
			if (n % 150 == 149)
				hold_until_drained();
		end
		hold_until_drained();
	endtask

	// Receiver: stalls for a random number of cycles, then takes one result.
	initial begin
		int hold;
		forever begin
			hold = $urandom_range(0, receiver_hold_max);
			repeat (hold) begin
				@(negedge clk);
				out_stall <= 1'b1;
			end
			@(negedge clk);
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid === 1'b1 && out_stall === 1'b0));
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (outcomes_due.size() == 0) begin
				note_mismatch("result with nothing pending", best_score, '0);
			end else begin
				want = outcomes_due.pop_front();
				if (accepted !== want.accepted)
					note_mismatch("accepted", WORD_W'(accepted), WORD_W'(want.accepted));
				if (placed_rank !== want.placed_rank)
					note_mismatch("placed_rank", WORD_W'(placed_rank),
						WORD_W'(want.placed_rank));
				if (entry_valid !== want.entry_valid)
					note_mismatch("entry_valid", WORD_W'(entry_valid),
						WORD_W'(want.entry_valid));
				if (entry_score !== want.entry.score)
					note_mismatch("entry_score", entry_score, want.entry.score);
				if (entry_payload_a !== want.entry.pa)
					note_mismatch("entry_payload_a", entry_payload_a, want.entry.pa);
				if (entry_payload_b !== want.entry.pb)
					note_mismatch("entry_payload_b", entry_payload_b, want.entry.pb);
				if (entry_time !== want.entry.pt)
					note_mismatch("entry_time", entry_time, want.entry.pt);
				if (best_score !== want.best_score)
					note_mismatch("best_score", best_score, want.best_score);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		action = ACT_SUBMIT;
		new_score = '0;
		payload_a = '0;
		payload_b = '0;
		payload_time = '0;
		query_rank = '0;
		mismatch_count = 0;
		cycle_count = 0;
		sender_gap_max = 3;
		receiver_hold_max = 3;
		foreach (board[i])
			board[i] = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_list();
		test_ranking_order();
		hold_until_drained();
		test_random_traffic(600, 6, 6);
		test_random_traffic(400, 0, 0);
		test_random_traffic(400, 0, 6);
		test_random_traffic(350, 6, 0);

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/stni_pkg.sv
rtl/stni_cell.sv
rtl/stni_outbuf.sv
rtl/sorted_top_n_insert.sv
tb/testbench.sv
